@@ design/stmm_pkg.sv @@
package stmm_pkg;

  // Fixed field widths of the stream and register interfaces
  localparam int unsigned IDX_IN_W = 4;
  localparam int unsigned VAL_IN_W = 16;
  localparam int unsigned ACC_W    = 40;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned IN_DW    = 24;
  localparam int unsigned OUT_DW   = 48;
  localparam int unsigned OUT_UW   = 3;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  // Input item kinds
  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_ACC  = 2'd1,
    ACT_FIN  = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  // Controller states
  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_SCAN_MUL = 6'b000100,
    ST_SCAN_ADD = 6'b001000,
    ST_FIN_CHK  = 6'b010000,
    ST_FIN_END  = 6'b100000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic store_b;
    logic set_drop;
    logic latch_a;
    logic scan_rd;
    logic scan_step;
    logic start_fin;
    logic acc_zero_wr;
    logic fin_adv;
    logic load_pend;
    logic push_pend;
    logic push_final;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic    in_valid;
    action_e act;
    logic    a_ok;
    logic    b_ok;
    logic    b_empty;
    logic    scan_last;
    logic    hit;
    logic    last_cell;
    logic    out_free;
    logic    pend_valid;
  } status_t;

endpackage

@@ design/sparse_triplet_matrix_multiply.sv @@
// Load-B beat: stored as accepted. A beat: each stored B triplet in turn is read
// (ST_SCAN_MUL), then added into the accumulator (ST_SCAN_ADD); s_axis_tready low.
// Finish beat: one accumulator cell a cycle, cleared as read, unless a nonzero cell
// waits for the output slot; the output side can also stall the final beat.
// Reset (rst_ni, async, active low): config regs to 8, B store and flags emptied,
// then a pass over all MAX_DIM*MAX_DIM cells zeroes accumulators, s_axis_tready low.
module sparse_triplet_matrix_multiply #(
  parameter int unsigned MAX_DIM       = 8,
  parameter int unsigned MAX_B_ENTRIES = 64,
  parameter int unsigned VALUE_WIDTH   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [stmm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input triplets
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [stmm_pkg::IN_DW-1:0]   s_axis_tdata,  // row[3:0], col[7:4], value[23:8]
  input  logic [1:0]                   s_axis_tuser,  // action[1:0]
  // product cells
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [stmm_pkg::OUT_DW-1:0]  m_axis_tdata,  // out_row[3:0], out_col[7:4],
                                                      // out_value[47:8]
  output logic [stmm_pkg::OUT_UW-1:0]  m_axis_tuser,  // empty_res[0], dim_error[1],
                                                      // dropped[2]
  output logic                         m_axis_tlast
);

  import stmm_pkg::*;

  cmd_t    ctrl_cmd;
  status_t dp_status;
  logic    cfg_we;

  assign pready        = 1'b1;
  assign cfg_we        = psel && penable && pwrite && pready;
  assign s_axis_tready = ctrl_cmd.in_ready;

  stmm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (dp_status),
    .cmd_o    (ctrl_cmd)
  );

  stmm_dpath #(
    .MAX_DIM       (MAX_DIM),
    .MAX_B_ENTRIES (MAX_B_ENTRIES),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .s_valid_i (s_axis_tvalid),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast),
    .cmd_i     (ctrl_cmd),
    .status_o  (dp_status)
  );

  // A beat only moves into the output register when the slot is free
  ap_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_cmd.push_pend || ctrl_cmd.push_final) |-> dp_status.out_free)
    else $error("output register overwritten");

  // A finish beat blocks the input side while cells are walked
  ap_fin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_FIN)) |=> !s_axis_tready)
    else $error("input accepted right after finish");

  // A cell beat never carries a zero value
  ap_no_zero_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[47:8] != '0))
    else $error("zero cell emitted");

endmodule

@@ design/stmm_ram.sv @@
module stmm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port (old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/stmm_ctrl.sv @@
module stmm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stmm_pkg::status_t status_i,
  output stmm_pkg::cmd_t    cmd_o
);

  import stmm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.acc_zero_wr = 1'b1;
        cmd_o.fin_adv     = 1'b1;
        if (status_i.last_cell) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          case (status_i.act)
            ACT_LOAD: begin
              if (status_i.b_ok) begin
                cmd_o.store_b = 1'b1;
              end else begin
                cmd_o.set_drop = 1'b1;
              end
            end
            ACT_ACC: begin
              if (status_i.a_ok) begin
                cmd_o.latch_a = 1'b1;
                if (!status_i.b_empty) begin
                  state_d = ST_SCAN_MUL;
                end
              end else begin
                cmd_o.set_drop = 1'b1;
              end
            end
            ACT_FIN: begin
              cmd_o.start_fin = 1'b1;
              state_d         = ST_FIN_CHK;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_MUL: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = ST_SCAN_ADD;
      end
      ST_SCAN_ADD: begin
        cmd_o.scan_step = 1'b1;
        state_d         = status_i.scan_last ? ST_IDLE : ST_SCAN_MUL;
      end
      ST_FIN_CHK: begin
        // a second nonzero cell must wait until the output slot frees up
        if (!(status_i.hit && status_i.pend_valid && !status_i.out_free)) begin
          cmd_o.acc_zero_wr = 1'b1;
          cmd_o.fin_adv     = 1'b1;
          if (status_i.hit) begin
            cmd_o.load_pend = 1'b1;
            cmd_o.push_pend = status_i.pend_valid;
          end
          if (status_i.last_cell) begin
            state_d = ST_FIN_END;
          end
        end
      end
      ST_FIN_END: begin
        if (status_i.out_free) begin
          cmd_o.push_final = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/stmm_dpath.sv @@
module stmm_dpath #(
  parameter int unsigned MAX_DIM       = 8,
  parameter int unsigned MAX_B_ENTRIES = 64,
  parameter int unsigned VALUE_WIDTH   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // register port
  input  logic                            cfg_we_i,
  input  logic [stmm_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  // input stream
  input  logic                            s_valid_i,
  input  logic [stmm_pkg::IN_DW-1:0]      s_data_i,
  input  logic [1:0]                      s_user_i,
  // output stream
  input  logic                            m_ready_i,
  output logic                            m_valid_o,
  output logic [stmm_pkg::OUT_DW-1:0]     m_data_o,
  output logic [stmm_pkg::OUT_UW-1:0]     m_user_o,
  output logic                            m_last_o,
  // control
  input  stmm_pkg::cmd_t                  cmd_i,
  output stmm_pkg::status_t               status_o
);

  import stmm_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_DIM);
  localparam int unsigned CELLS  = MAX_DIM * MAX_DIM;
  localparam int unsigned CELL_W = $clog2(CELLS);
  localparam int unsigned BA_W   = $clog2(MAX_B_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(MAX_B_ENTRIES + 1);
  localparam int unsigned BW     = 2 * IDX_W + VALUE_WIDTH;
  localparam int unsigned PROD_W = 2 * VALUE_WIDTH;
  localparam int unsigned CMP_W  = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

  // Effective dimension check: 1 <= idx <= min(dim, MAX_DIM)
  function automatic logic in_rng(logic [IDX_IN_W-1:0] idx, logic [CFG_W-1:0] dim);
    logic [CMP_W-1:0] eff;
    eff = (CMP_W'(dim) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : CMP_W'(dim);
    return (idx != '0) && (CMP_W'(idx) <= eff);
  endfunction

  function automatic logic idx_lt(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] dim);
    logic [CMP_W-1:0] eff;
    eff = (CMP_W'(dim) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : CMP_W'(dim);
    return CMP_W'(idx) < eff;
  endfunction

  // ---------------- configuration registers ----------------
  logic [CFG_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= CFG_W'(8);
      a_cols_q <= CFG_W'(8);
      b_rows_q <= CFG_W'(8);
      b_cols_q <= CFG_W'(8);
    end else if (cfg_we_i) begin
      case (paddr[3:2])
        REG_A_ROWS: a_rows_q <= pwdata[CFG_W-1:0];
        REG_A_COLS: a_cols_q <= pwdata[CFG_W-1:0];
        REG_B_ROWS: b_rows_q <= pwdata[CFG_W-1:0];
        REG_B_COLS: b_cols_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_A_ROWS: prdata = 32'(a_rows_q);
      REG_A_COLS: prdata = 32'(a_cols_q);
      REG_B_ROWS: prdata = 32'(b_rows_q);
      REG_B_COLS: prdata = 32'(b_cols_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------- input beat decode ----------------
  logic [IDX_IN_W-1:0]    in_row, in_col;
  logic [VAL_IN_W-1:0]    in_val_raw;
  logic [VALUE_WIDTH-1:0] in_val;
  logic [IDX_W-1:0]       in_row0, in_col0;

  assign in_row     = s_data_i[3:0];
  assign in_col     = s_data_i[7:4];
  assign in_val_raw = s_data_i[23:8];
  assign in_val     = VALUE_WIDTH'(in_val_raw);
  assign in_row0    = IDX_W'(in_row - IDX_IN_W'(1));
  assign in_col0    = IDX_W'(in_col - IDX_IN_W'(1));

  // ---------------- sticky state ----------------
  logic [CNT_W-1:0] b_count_q;
  logic             dropped_q;
  logic             dim_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_count_q <= '0;
      dropped_q <= 1'b0;
    end else begin
      if (cmd_i.store_b) begin
        b_count_q <= b_count_q + CNT_W'(1);
      end
      if (cmd_i.set_drop) begin
        dropped_q <= 1'b1;
      end
      if (cmd_i.push_final) begin
        b_count_q <= '0;
        dropped_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_fin) begin
      dim_err_q <= (a_cols_q != b_rows_q);
    end
  end

  // ---------------- B store ----------------
  logic [BA_W-1:0] k_q;
  logic [BA_W-1:0] b_raddr;
  logic [BW-1:0]   b_wdata, b_rdata;
  logic [IDX_W-1:0]       b_row_rd, b_col_rd;
  logic [VALUE_WIDTH-1:0] b_val_rd;

  assign b_wdata = {in_row0, in_col0, in_val};
  assign b_raddr = cmd_i.scan_step ? k_q + BA_W'(1) : k_q;
  assign {b_row_rd, b_col_rd, b_val_rd} = b_rdata;

  stmm_ram #(
    .WIDTH (BW),
    .DEPTH (MAX_B_ENTRIES)
  ) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store_b),
    .waddr_i (b_count_q[BA_W-1:0]),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // scan index over stored B triplets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.scan_step) begin
      k_q <= status_o.scan_last ? '0 : k_q + BA_W'(1);
    end
  end

  // ---------------- A triplet and multiply ----------------
  logic [IDX_W-1:0]              a_row_q, a_col_q;
  logic signed [VALUE_WIDTH-1:0] a_val_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic                          hit_q;
  logic [CELL_W-1:0]             cell_q;
  logic [CELL_W-1:0]             scan_cell;

  assign scan_cell = CELL_W'(a_row_q) * CELL_W'(MAX_DIM) + CELL_W'(b_col_rd);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_a) begin
      a_row_q <= in_row0;
      a_col_q <= in_col0;
      a_val_q <= $signed(in_val);
    end
    if (cmd_i.scan_rd) begin
      prod_q <= a_val_q * $signed(b_val_rd);
      hit_q  <= (b_row_rd == a_col_q);
      cell_q <= scan_cell;
    end
  end

  // ---------------- accumulator memory ----------------
  logic [IDX_W-1:0]  i_q, j_q, i_nx, j_nx;
  logic              last_cell;
  logic [CELL_W-1:0] cur_cell, nx_cell;
  logic              acc_we;
  logic [CELL_W-1:0] acc_waddr, acc_raddr;
  logic [ACC_W-1:0]  acc_wdata, acc_rdata;

  assign last_cell = (i_q == IDX_W'(MAX_DIM - 1)) && (j_q == IDX_W'(MAX_DIM - 1));

  // row-major cell walk
  always_comb begin
    i_nx = i_q;
    j_nx = j_q + IDX_W'(1);
    if (j_q == IDX_W'(MAX_DIM - 1)) begin
      j_nx = '0;
      i_nx = (i_q == IDX_W'(MAX_DIM - 1)) ? '0 : i_q + IDX_W'(1);
    end
  end

  assign cur_cell = CELL_W'(i_q) * CELL_W'(MAX_DIM) + CELL_W'(j_q);
  assign nx_cell  = CELL_W'(i_nx) * CELL_W'(MAX_DIM) + CELL_W'(j_nx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.fin_adv) begin
      i_q <= i_nx;
      j_q <= j_nx;
    end
  end

  assign acc_raddr = cmd_i.scan_rd ? scan_cell : (cmd_i.fin_adv ? nx_cell : cur_cell);
  assign acc_we    = cmd_i.acc_zero_wr || (cmd_i.scan_step && hit_q);
  assign acc_waddr = cmd_i.acc_zero_wr ? cur_cell : cell_q;
  assign acc_wdata = cmd_i.acc_zero_wr ? '0 : acc_rdata + ACC_W'(prod_q);

  stmm_ram #(
    .WIDTH (ACC_W),
    .DEPTH (CELLS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // ---------------- pending cell (held back to mark the last beat) ----------------
  logic [IDX_W-1:0] pend_i_q, pend_j_q;
  logic [ACC_W-1:0] pend_val_q;
  logic             pend_valid_q;
  logic [IDX_W:0]   pend_row1, pend_col1;

  assign pend_row1 = {1'b0, pend_i_q} + (IDX_W + 1)'(1);
  assign pend_col1 = {1'b0, pend_j_q} + (IDX_W + 1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.load_pend) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.push_final) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pend) begin
      pend_i_q   <= i_q;
      pend_j_q   <= j_q;
      pend_val_q <= acc_rdata;
    end
  end

  // ---------------- output register ----------------
  logic                out_valid_q;
  logic [IDX_IN_W-1:0] out_row_q, out_col_q;
  logic [ACC_W-1:0]    out_val_q;
  logic                out_empty_q, out_derr_q, out_drop_q, out_last_q;
  logic                out_free;

  assign out_free = !out_valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_pend || cmd_i.push_final) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_pend || (cmd_i.push_final && pend_valid_q)) begin
      out_row_q   <= IDX_IN_W'(pend_row1);
      out_col_q   <= IDX_IN_W'(pend_col1);
      out_val_q   <= pend_val_q;
      out_empty_q <= 1'b0;
      out_derr_q  <= 1'b0;
      out_drop_q  <= dropped_q;
      out_last_q  <= cmd_i.push_final;
    end else if (cmd_i.push_final) begin
      // empty marker
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_val_q   <= '0;
      out_empty_q <= 1'b1;
      out_derr_q  <= dim_err_q;
      out_drop_q  <= dropped_q;
      out_last_q  <= 1'b1;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {out_val_q, out_col_q, out_row_q};
  assign m_user_o  = {out_drop_q, out_derr_q, out_empty_q};
  assign m_last_o  = out_last_q;

  // ---------------- status ----------------
  assign status_o.in_valid   = s_valid_i;
  assign status_o.act        = action_e'(s_user_i);
  assign status_o.a_ok       = in_rng(in_row, a_rows_q) && in_rng(in_col, a_cols_q);
  assign status_o.b_ok       = in_rng(in_row, b_rows_q) && in_rng(in_col, b_cols_q) &&
                               (b_count_q != CNT_W'(MAX_B_ENTRIES));
  assign status_o.b_empty    = (b_count_q == '0);
  assign status_o.scan_last  = (CNT_W'(k_q) + CNT_W'(1) == b_count_q);
  assign status_o.hit        = !dim_err_q && idx_lt(i_q, a_rows_q) &&
                               idx_lt(j_q, b_cols_q) && (acc_rdata != '0);
  assign status_o.last_cell  = last_cell;
  assign status_o.out_free   = out_free;
  assign status_o.pend_valid = pend_valid_q;

endmodule
